### src/vbec_pkg.sv
package vbec_pkg;

    localparam int SMP_W   = 16;
    localparam int BIN_W   = 7;
    localparam int MAG_W   = 24;
    localparam int SUM_W   = 25;
    localparam int SQ_W    = 40;
    localparam int EN_W    = 56;
    localparam int PROD_W  = 50;
    localparam int RAT_W   = 16;
    localparam int CFG_W   = 7;
    localparam int ADDR_W  = 3;
    localparam int SCORE_W = 7;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 104;
    localparam int ITER_N  = 16;
    localparam int CNT_W   = 4;
    localparam int REM_W   = 57;
    localparam int RES_W   = 32;
    localparam int SBIT_W  = 31;

    // thresholds, Q4.12 and Q0.16
    localparam logic [15:0] RMS_GOOD = 16'd2909;
    localparam logic [15:0] RMS_SAT  = 16'd7373;
    localparam logic [15:0] RMS_UNS  = 16'd18432;
    localparam logic [15:0] HF_LIM   = 16'd18350;
    localparam logic [15:0] HARM_LIM = 16'd14418;
    localparam logic [15:0] FUND_LIM = 16'd19661;
    localparam logic [15:0] HARM_LOW = 16'd11796;

    typedef enum logic [ADDR_W-1:0] {
        REG_FUND_LO = 3'd0,
        REG_FUND_HI = 3'd1,
        REG_HARM_LO = 3'd2,
        REG_HARM_HI = 3'd3,
        REG_HF_LO   = 3'd4,
        REG_HF_HI   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        HS_GOOD  = 2'd0,
        HS_SAT   = 2'd1,
        HS_UNSAT = 2'd2,
        HS_UNACC = 2'd3
    } health_t;

    typedef enum logic [1:0] {
        FK_NORMAL  = 2'd0,
        FK_UNBAL   = 2'd1,
        FK_MISALGN = 2'd2,
        FK_BEARING = 2'd3
    } fault_t;

    typedef enum logic {
        MODE_SQRT = 1'b0,
        MODE_DIV  = 1'b1
    } iter_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_VMUL,
        ST_VAR,
        ST_SQRT,
        ST_DSET,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef struct packed {
        logic             done;
        logic [RAT_W-1:0] result;
    } iter_rsp_t;

endpackage

### src/vibration_band_energy_classifier_unit.sv
// Each item passes through load, shared multiply and accumulate; a new item is taken
// only once the last is accumulated. A frame-end bin then needs a 16-step root and up
// to three 16-step divisions (each skipped when the total is zero or not above the
// band) on one shared compare/subtract unit, before the result beat.
// The result sits in an output register; input is taken again once it is loaded.
// rst_n is asynchronous: accumulators clear and band registers take their defaults.
module vibration_band_energy_classifier_unit
    import vbec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // sample_value, bin_index, magnitude, pad
    input  logic              s_tlast,  // frame_end
    input  logic              s_tuser,  // action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,  // rms, peak, fund, harm, hf, state, fault, score, pad
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    state_t state_reg, state_next;

    logic [BIN_W-1:0] fund_lo_reg, fund_hi_reg, harm_lo_reg, harm_hi_reg;
    logic [BIN_W-1:0] hf_lo_reg, hf_hi_reg;

    logic             act_reg, fend_reg;
    logic [SMP_W-1:0] smp_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [MAG_W-1:0] mag_reg;

    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [EN_W-1:0]   tot_reg, fund_reg, harm_reg, hf_reg;
    logic [MAG_W-1:0]  peak_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [15:0]       rms_reg;
    logic [RAT_W-1:0]  ratio_reg [3];
    logic [1:0]        idx_reg;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic [SUM_W-1:0]  smp_ext, mul_op, s1_abs;
    logic [PROD_W-1:0] var_diff;
    logic [EN_W-1:0]   band_sel, var_val;
    iter_req_t         req;
    iter_rsp_t         rsp;
    health_t           hs;
    fault_t            fk;
    logic [SCORE_W-1:0] score;
    logic              load_out;

    assign smp_ext = {{(SUM_W-SMP_W){smp_reg[SMP_W-1]}}, smp_reg};
    assign s1_abs  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_comb
    begin
        if (state_reg == ST_VMUL)
            mul_op = s1_abs;
        else if (act_reg)
            mul_op = {1'b0, mag_reg};
        else
            mul_op = smp_ext[SUM_W-1] ? (~smp_ext + 1'b1) : smp_ext;
    end

    // 256*S2 - S1^2, then divide by 256^2
    assign var_diff = {2'b0, sq_reg, 8'b0} - {1'b0, prod_reg[PROD_W-2:0]};
    assign var_val  = (!var_diff[PROD_W-1] && var_diff != '0)
                      ? {24'b0, var_diff[47:16]} : '0;

    always_comb
    begin
        case (idx_reg)
            2'd0:    band_sel = fund_reg;
            2'd1:    band_sel = harm_reg;
            default: band_sel = hf_reg;
        endcase
    end

    vbec_iter u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .operand ((state_reg == ST_VAR) ? var_val : band_sel),
        .divisor (tot_reg),
        .rsp     (rsp)
    );

    vbec_class u_class (
        .rms   (rms_reg),
        .fund  (ratio_reg[0]),
        .harm  (ratio_reg[1]),
        .hf    (ratio_reg[2]),
        .state (hs),
        .fault (fk),
        .score (score)
    );

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        req.start  = 1'b0;
        req.mode   = MODE_SQRT;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = (act_reg && fend_reg) ? ST_VMUL : ST_IDLE;
            ST_VMUL: state_next = ST_VAR;
            ST_VAR:
            begin
                req.start  = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (rsp.done)
                    state_next = ST_DSET;
            end
            ST_DSET:
            begin
                if (tot_reg == '0 || band_sel >= tot_reg)
                    state_next = (idx_reg == 2'd2) ? ST_OUT : ST_DSET;
                else
                begin
                    req.start  = 1'b1;
                    req.mode   = MODE_DIV;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rsp.done)
                    state_next = (idx_reg == 2'd2) ? ST_OUT : ST_DSET;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fund_lo_reg <= 7'd5;
            fund_hi_reg <= 7'd8;
            harm_lo_reg <= 7'd11;
            harm_hi_reg <= 7'd14;
            hf_lo_reg   <= 7'd30;
            hf_hi_reg   <= 7'd63;
            sum_reg     <= '0;
            sq_reg      <= '0;
            tot_reg     <= '0;
            fund_reg    <= '0;
            harm_reg    <= '0;
            hf_reg      <= '0;
            peak_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FUND_LO: fund_lo_reg <= cfg_wdata;
                    REG_FUND_HI: fund_hi_reg <= cfg_wdata;
                    REG_HARM_LO: harm_lo_reg <= cfg_wdata;
                    REG_HARM_HI: harm_hi_reg <= cfg_wdata;
                    REG_HF_LO:   hf_lo_reg   <= cfg_wdata;
                    REG_HF_HI:   hf_hi_reg   <= cfg_wdata;
                    default:     ;
                endcase
            end

            if (state_reg == ST_ACC)
            begin
                if (!act_reg)
                begin
                    sum_reg <= sum_reg + smp_ext;
                    sq_reg  <= sq_reg + prod_reg[SQ_W-1:0];
                end
                else if (bin_reg != '0)
                begin
                    tot_reg <= tot_reg + {8'b0, prod_reg[47:0]};
                    if (mag_reg > peak_reg)
                        peak_reg <= mag_reg;
                    if (bin_reg >= fund_lo_reg && bin_reg <= fund_hi_reg)
                        fund_reg <= fund_reg + {8'b0, prod_reg[47:0]};
                    if (bin_reg >= harm_lo_reg && bin_reg <= harm_hi_reg)
                        harm_reg <= harm_reg + {8'b0, prod_reg[47:0]};
                    if (bin_reg >= hf_lo_reg && bin_reg <= hf_hi_reg)
                        hf_reg <= hf_reg + {8'b0, prod_reg[47:0]};
                end
            end

            if (state_reg == ST_SQRT)
                idx_reg <= '0;
            else if ((state_reg == ST_DSET && !req.start) || (state_reg == ST_DIV && rsp.done))
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 1'b1;

            if (load_out)
            begin
                m_valid_reg <= 1'b1;
                sum_reg  <= '0;
                sq_reg   <= '0;
                tot_reg  <= '0;
                fund_reg <= '0;
                harm_reg <= '0;
                hf_reg   <= '0;
                peak_reg <= '0;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg  <= s_tuser;
            fend_reg <= s_tlast;
            smp_reg  <= s_tdata[15:0];
            bin_reg  <= s_tdata[22:16];
            mag_reg  <= s_tdata[46:23];
        end
        if (state_reg == ST_MUL || state_reg == ST_VMUL)
            prod_reg <= mul_op * mul_op;
        if (state_reg == ST_SQRT && rsp.done)
            rms_reg <= rsp.result;
        if (state_reg == ST_DSET && !req.start)
            ratio_reg[idx_reg] <= (tot_reg == '0) ? '0 : '1;
        if (state_reg == ST_DIV && rsp.done)
            ratio_reg[idx_reg] <= rsp.result;
        if (load_out)
            m_data_reg <= {5'b0, score, fk, hs, ratio_reg[2], ratio_reg[1], ratio_reg[0],
                           peak_reg, rms_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### src/vbec_iter.sv
module vbec_iter
    import vbec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  iter_req_t       req,
    input  logic [EN_W-1:0] operand,
    input  logic [EN_W-1:0] divisor,
    output iter_rsp_t       rsp
);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RES_W-1:0]  q_reg, q_next;
    logic [SBIT_W-1:0] sbit_reg, sbit_next;
    logic [EN_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    iter_mode_t        mode_reg, mode_next;

    logic [REM_W:0] cmp_a, cmp_b, diff;
    logic           ge;

    // one shared compare/subtract serves both root and division steps
    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            cmp_a = {1'b0, rem_reg};
            cmp_b = {{(REM_W-RES_W+1){1'b0}}, q_reg + {1'b0, sbit_reg}};
        end
        else
        begin
            cmp_a = {rem_reg, 1'b0};
            cmp_b = {2'b0, den_reg};
        end
        diff = cmp_a - cmp_b;
        ge   = !diff[REM_W];
    end

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        sbit_next = sbit_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, operand};
            q_next    = '0;
            sbit_next = {1'b1, {(SBIT_W-1){1'b0}}};
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            mode_next = req.mode;
        end
        else if (busy_reg)
        begin
            if (mode_reg == MODE_SQRT)
            begin
                if (ge)
                begin
                    rem_next = diff[REM_W-1:0];
                    q_next   = (q_reg >> 1) + {1'b0, sbit_reg};
                end
                else
                begin
                    q_next = q_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            else
            begin
                rem_next = ge ? diff[REM_W-1:0] : {rem_reg[REM_W-2:0], 1'b0};
                q_next   = {q_reg[RES_W-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= MODE_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sbit_reg <= sbit_next;
        den_reg  <= den_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = q_reg[RAT_W-1:0];

endmodule

### src/vbec_class.sv
module vbec_class
    import vbec_pkg::*;
(
    input  logic [15:0]        rms,
    input  logic [RAT_W-1:0]   fund,
    input  logic [RAT_W-1:0]   harm,
    input  logic [RAT_W-1:0]   hf,
    output health_t            state,
    output fault_t             fault,
    output logic [SCORE_W-1:0] score
);

    logic [SCORE_W-1:0] base, penalty;
    logic [23:0]        harm_x100, fund_x65;

    assign harm_x100 = {8'b0, harm} * 24'd100;
    assign fund_x65  = {8'b0, fund} * 24'd65;

    always_comb
    begin
        if (rms < RMS_GOOD)
        begin
            state = HS_GOOD;
            base  = 7'd100;
        end
        else if (rms < RMS_SAT)
        begin
            state = HS_SAT;
            base  = 7'd80;
        end
        else if (rms < RMS_UNS)
        begin
            state = HS_UNSAT;
            base  = 7'd45;
        end
        else
        begin
            state = HS_UNACC;
            base  = 7'd10;
        end

        if (hf > HF_LIM)
        begin
            fault   = FK_BEARING;
            penalty = 7'd25;
        end
        else if (harm > HARM_LIM && harm_x100 > fund_x65)
        begin
            fault   = FK_MISALGN;
            penalty = 7'd15;
        end
        else if (fund > FUND_LIM && harm < HARM_LOW)
        begin
            fault   = FK_UNBAL;
            penalty = 7'd10;
        end
        else
        begin
            fault   = FK_NORMAL;
            penalty = 7'd0;
        end

        score = (base > penalty) ? base - penalty : '0;
    end

endmodule
